@@ src/cqt_pkg.sv @@
// Shared types and constants of the cosigner quorum tracker.
// No dependencies; imported by cqt_fp_store, cosigner_quorum_tracker and the testbench.
package cqt_pkg;

  localparam int unsigned FP_W    = 32;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CNT_OUT_W = 5;
  localparam logic [7:0]  NO_SLOT = 8'hFF;
  localparam logic [CNT_OUT_W-1:0] CNT_SAT = 5'd31;

  // Configuration register indexes
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_COUNT     = 2'd1;
  localparam logic [1:0] CFG_OWN_SLOT  = 2'd2;

  typedef enum logic [2:0] {
    ACT_LOAD     = 3'd0,
    ACT_LOOKUP   = 3'd1,
    ACT_RECORD   = 3'd2,
    ACT_CLEAR    = 3'd3,
    ACT_VALIDATE = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_VREF,
    ST_VLOAD,
    ST_VCMP,
    ST_COUNT,
    ST_FINISH
  } state_e;

  // Strobes from the sequencer to the fingerprint store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

endpackage

@@ src/cqt_fp_store.sv @@
// Fingerprint store: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero. Uses cqt_pkg.
module cqt_fp_store import cqt_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  store_ctl_t       ctl_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [FP_W-1:0]  wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output logic [FP_W-1:0]  rdata_o
);

  logic [FP_W-1:0]  mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [FP_W-1:0]  rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.wr_en) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rd_q     <= mem_q[raddr_i];
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  // Never-written entries read as zero
  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

@@ src/cosigner_quorum_tracker.sv @@
// Cosigner quorum tracker: M-of-N fingerprint table with signature marks.
// n = min(cosigner_count, MAX_COSIGNERS) slots are in use. Every beat ends by counting the
// marks of the n slots; lookup and record first search the n slots, and a validate that passes
// the range checks first compares the n entries pairwise. Each walk goes through the single
// store read port and one 32-bit comparator. One beat in flight at a time.
// Reset clears the table and marks at once (valid bits). Uses cqt_pkg and cqt_fp_store.
module cosigner_quorum_tracker import cqt_pkg::*; #(
  parameter int unsigned MAX_COSIGNERS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           action_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  logic [FP_W-1:0]      fingerprint_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SLOT_W-1:0]    found_slot_o,
  output logic                 known_o,
  output logic [CNT_OUT_W-1:0] signed_count_o,
  output logic                 quorum_met_o,
  output logic                 config_valid_o
);

  localparam int unsigned IDX_W = (MAX_COSIGNERS > 1) ? $clog2(MAX_COSIGNERS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_COSIGNERS + 1);

  // Configuration registers
  logic [CFG_W-1:0] thr_q, cc_q, own_q;

  // Sequencer control state
  state_e                   state_q, state_d;
  logic [MAX_COSIGNERS-1:0] mark_q, mark_d;
  logic                     out_valid_q, out_valid_d;

  // Working registers of the current beat
  action_e              act_q, act_d;
  logic [FP_W-1:0]      fp_q, fp_d;
  logic [FP_W-1:0]      ref_q, ref_d;
  logic [CNT_W-1:0]     idx_q, idx_d;      // walk address counter
  logic [CNT_W-1:0]     ri_q, ri_d;        // outer index of the pairwise check
  logic                 rv_q, rv_d;        // store read data is live this cycle
  logic [IDX_W-1:0]     ridx_q, ridx_d;    // slot the live read data came from
  logic [IDX_W-1:0]     found_q, found_d;
  logic                 known_q, known_d;
  logic                 valid_q, valid_d;
  logic                 dup_q, dup_d;
  logic [CNT_OUT_W-1:0] cnt_q, cnt_d;

  // Output register
  logic [SLOT_W-1:0]    o_found_q, o_found_d;
  logic                 o_known_q, o_known_d;
  logic [CNT_OUT_W-1:0] o_cnt_q, o_cnt_d;
  logic                 o_quorum_q, o_quorum_d;
  logic                 o_valid_q, o_valid_d;

  // Store interface
  store_ctl_t       st_ctl;
  logic [IDX_W-1:0] rd_addr;
  logic [FP_W-1:0]  rdata;

  logic [CNT_W-1:0] n_use;
  logic             accept;
  logic             scalar_ok;
  logic             hit;
  logic             walk_more;
  logic             walk_done;

  cqt_fp_store #(
    .DEPTH (MAX_COSIGNERS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (st_ctl),
    .waddr_i (IDX_W'(slot_i)),
    .wdata_i (fingerprint_i),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // Slots in use: the count, capped at the table depth
  assign n_use = (cc_q >= MAX_COSIGNERS) ? CNT_W'(MAX_COSIGNERS) : CNT_W'(cc_q);

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // Range checks of validation; the pairwise walk runs only if these pass
  assign scalar_ok = (thr_q != '0) && (thr_q <= cc_q) &&
                     (cc_q != '0) && (cc_q <= MAX_COSIGNERS) &&
                     ((own_q == NO_SLOT) || (own_q < cc_q));

  // The one shared comparator: fingerprint for search, held entry for validation
  assign hit       = (rdata == ((state_q == ST_VCMP) ? ref_q : fp_q));
  assign walk_more = (idx_q < n_use);
  assign walk_done = !rv_q && !walk_more;

  always_comb begin
    state_d     = state_q;
    mark_d      = mark_q;
    out_valid_d = out_valid_q;
    act_d       = act_q;
    fp_d        = fp_q;
    ref_d       = ref_q;
    idx_d       = idx_q;
    ri_d        = ri_q;
    rv_d        = rv_q;
    ridx_d      = ridx_q;
    found_d     = found_q;
    known_d     = known_q;
    valid_d     = valid_q;
    dup_d       = dup_q;
    cnt_d       = cnt_q;
    o_found_d   = o_found_q;
    o_known_d   = o_known_q;
    o_cnt_d     = o_cnt_q;
    o_quorum_d  = o_quorum_q;
    o_valid_d   = o_valid_q;
    st_ctl      = '0;
    rd_addr     = idx_q[IDX_W-1:0];

    // Drop the result once the sink takes it
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          act_d   = action_e'(action_i);
          fp_d    = fingerprint_i;
          idx_d   = '0;
          ri_d    = '0;
          rv_d    = 1'b0;
          found_d = '0;
          known_d = 1'b0;
          valid_d = 1'b0;
          dup_d   = 1'b0;
          cnt_d   = '0;
          case (action_e'(action_i))
            ACT_LOAD: begin
              // Slots beyond the table are ignored
              if (slot_i < MAX_COSIGNERS) begin
                st_ctl.wr_en = 1'b1;
              end
              state_d = ST_COUNT;
            end
            ACT_LOOKUP, ACT_RECORD: begin
              state_d = ST_SEARCH;
            end
            ACT_CLEAR: begin
              mark_d  = '0;
              state_d = ST_COUNT;
            end
            ACT_VALIDATE: begin
              if (scalar_ok) begin
                valid_d = 1'b1;
                state_d = ST_VREF;
              end else begin
                state_d = ST_COUNT;
              end
            end
            default: begin
              state_d = ST_COUNT;
            end
          endcase
        end
      end

      // Walk the slots in use, with each read issued the cycle before its compare
      ST_SEARCH, ST_VCMP: begin
        if (walk_more) begin
          st_ctl.rd_en = 1'b1;
          idx_d        = idx_q + 1'b1;
          rv_d         = 1'b1;
          ridx_d       = idx_q[IDX_W-1:0];
        end else begin
          rv_d = 1'b0;
        end
        if (rv_q && hit) begin
          if (state_q == ST_SEARCH) begin
            // Keep the lowest matching slot
            if (!known_q) begin
              known_d = 1'b1;
              found_d = ridx_q;
            end
          end else begin
            dup_d = 1'b1;
          end
        end
        if (walk_done) begin
          if (state_q == ST_SEARCH) begin
            if ((act_q == ACT_RECORD) && known_q) begin
              mark_d[found_q] = 1'b1;
            end
            idx_d   = '0;
            state_d = ST_COUNT;
          end else if (dup_q) begin
            valid_d = 1'b0;
            idx_d   = '0;
            state_d = ST_COUNT;
          end else begin
            ri_d    = ri_q + 1'b1;
            state_d = ST_VREF;
          end
        end
      end

      // Fetch the entry every later slot is compared against, or end the pairwise check after the last
      ST_VREF: begin
        if (({1'b0, ri_q} + 1'b1) >= {1'b0, n_use}) begin
          idx_d   = '0;
          state_d = ST_COUNT;
        end else begin
          st_ctl.rd_en = 1'b1;
          rd_addr      = ri_q[IDX_W-1:0];
          state_d      = ST_VLOAD;
        end
      end

      ST_VLOAD: begin
        ref_d   = rdata;
        idx_d   = ri_q + 1'b1;
        rv_d    = 1'b0;
        dup_d   = 1'b0;
        state_d = ST_VCMP;
      end

      // Count marks below the slots in use, one slot a cycle
      ST_COUNT: begin
        if (walk_more) begin
          idx_d = idx_q + 1'b1;
          if (mark_q[idx_q[IDX_W-1:0]] && (cnt_q != CNT_SAT)) begin
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          state_d = ST_FINISH;
        end
      end

      // Hold until the output register is free
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          o_found_d   = SLOT_W'(found_q);
          o_known_d   = known_q;
          o_cnt_d     = cnt_q;
          o_quorum_d  = ({3'b000, cnt_q} >= thr_q);
          o_valid_d   = valid_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mark_q      <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= 8'd1;
      cc_q        <= 8'd1;
      own_q       <= NO_SLOT;
    end else begin
      state_q     <= state_d;
      mark_q      <= mark_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_THRESHOLD: thr_q <= cfg_wdata_i;
          CFG_COUNT:     cc_q  <= cfg_wdata_i;
          CFG_OWN_SLOT:  own_q <= cfg_wdata_i;
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    fp_q       <= fp_d;
    ref_q      <= ref_d;
    idx_q      <= idx_d;
    ri_q       <= ri_d;
    rv_q       <= rv_d;
    ridx_q     <= ridx_d;
    found_q    <= found_d;
    known_q    <= known_d;
    valid_q    <= valid_d;
    dup_q      <= dup_d;
    cnt_q      <= cnt_d;
    o_found_q  <= o_found_d;
    o_known_q  <= o_known_d;
    o_cnt_q    <= o_cnt_d;
    o_quorum_q <= o_quorum_d;
    o_valid_q  <= o_valid_d;
  end

  assign out_valid_o    = out_valid_q;
  assign found_slot_o   = o_found_q;
  assign known_o        = o_known_q;
  assign signed_count_o = o_cnt_q;
  assign quorum_met_o   = o_quorum_q;
  assign config_valid_o = o_valid_q;

endmodule

@@ sim/cosigner_quorum_tracker_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for cosigner_quorum_tracker: directed script, then random phases.
// Needs cqt_pkg and the tracker RTL; results are checked by an in-bench quorum predictor.
module cosigner_quorum_tracker_test;
  import cqt_pkg::*;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned PHASES      = 16;
  localparam int unsigned PHASE_ITEMS = 120;
  localparam int unsigned GUARD       = 4;    // quiet cycles before a register write
  localparam int unsigned DRAIN       = 300;  // longer than a full 16-slot validate

  // Action codes 5..7 are unused by the block
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  // Register index 3 is outside the map and must be ignored
  localparam logic [1:0] CFG_SPARE    = 2'd3;

  typedef struct packed {
    logic [SLOT_W-1:0]    found;
    logic                 known;
    logic [CNT_OUT_W-1:0] marked;
    logic                 quorum;
    logic                 valid;
  } tally_t;

  // One line of the directed script: a register write or an input beat
  typedef struct packed {
    bit                is_reg;
    logic [1:0]        idx;
    logic [CFG_W-1:0]  val;
    logic [2:0]        act;
    logic [SLOT_W-1:0] slot;
    logic [FP_W-1:0]   fp;
    bit                typed;   // use the typed-in tally instead of the predictor's
    tally_t            want;
  } script_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [1:0]           cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [2:0]           action_i;
  logic [SLOT_W-1:0]    slot_i;
  logic [FP_W-1:0]      fingerprint_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [SLOT_W-1:0]    found_slot_o;
  logic                 known_o;
  logic [CNT_OUT_W-1:0] signed_count_o;
  logic                 quorum_met_o;
  logic                 config_valid_o;

  // Predictor state: fingerprint table, signature marks and the three registers
  logic [FP_W-1:0]  fp_table [SLOTS];
  logic [SLOTS-1:0] marks;
  logic [CFG_W-1:0] cfg_thr;
  logic [CFG_W-1:0] cfg_count;
  logic [CFG_W-1:0] cfg_own;

  tally_t      pending_tallies [$];
  tally_t      head;
  script_row_t script [$];
  int unsigned mismatches = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;

  cosigner_quorum_tracker #(
    .MAX_COSIGNERS(SLOTS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .slot_i        (slot_i),
    .fingerprint_i (fingerprint_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_slot_o  (found_slot_o),
    .known_o       (known_o),
    .signed_count_o(signed_count_o),
    .quorum_met_o  (quorum_met_o),
    .config_valid_o(config_valid_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Advance the quorum predictor by one accepted beat and return the tally it must produce.
  function automatic tally_t tally_step(input logic [2:0] act, input logic [SLOT_W-1:0] slot,
                                        input logic [FP_W-1:0] fp);
    tally_t      r;
    int unsigned in_use;
    int unsigned cnt;
    bit          ok;
    r = '0;
    in_use = (cfg_count < SLOTS) ? cfg_count : SLOTS;
    case (act)
      ACT_LOAD: fp_table[slot] = fp;  // marks stay as they are
      ACT_LOOKUP, ACT_RECORD: begin
        // lowest matching slot among the slots in use wins
        for (int i = 0; i < in_use; i++) begin
          if (!r.known && fp_table[i] == fp) begin
            r.known = 1'b1;
            r.found = SLOT_W'(i);
          end
        end
        if (r.known && act == ACT_RECORD) marks[r.found] = 1'b1;
      end
      ACT_CLEAR: marks = '0;
      ACT_VALIDATE: begin
        ok = (cfg_thr >= 1) && (cfg_thr <= cfg_count) && (cfg_count >= 1) &&
             (cfg_count <= SLOTS) && (cfg_own == NO_SLOT || cfg_own < cfg_count);
        // pairwise uniqueness, only reachable once the count is known to fit
        if (ok) begin
          for (int i = 0; i < cfg_count; i++)
            for (int j = i + 1; j < cfg_count; j++)
              if (fp_table[i] == fp_table[j]) ok = 1'b0;
        end
        r.valid = ok;
      end
      default: ;  // unused codes: report only
    endcase
    cnt = 0;
    for (int i = 0; i < in_use; i++) if (marks[i]) cnt++;
    r.marked = (cnt > CNT_SAT) ? CNT_SAT : CNT_OUT_W'(cnt);
    r.quorum = (r.marked >= cfg_thr);
    return r;
  endfunction

  function automatic script_row_t reg_row(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    script_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.idx = idx;
    row.val = val;
    return row;
  endfunction

  function automatic script_row_t op_row(input logic [2:0] act, input logic [SLOT_W-1:0] slot,
                                         input logic [FP_W-1:0] fp);
    script_row_t row;
    row = '0;
    row.act = act;
    row.slot = slot;
    row.fp = fp;
    return row;
  endfunction

  function automatic script_row_t checked_row(input logic [2:0] act,
                                              input logic [SLOT_W-1:0] slot,
                                              input logic [FP_W-1:0] fp, input tally_t want);
    script_row_t row;
    row = op_row(act, slot, fp);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  // Mostly reuse table contents so lookups and records hit; sometimes a fresh value.
  function automatic logic [FP_W-1:0] pick_fp();
    if ($urandom_range(3) != 0) return fp_table[$urandom_range(SLOTS - 1)];
    return $urandom;
  endfunction

  // Drop valid until nothing is in flight, then wait out the GUARD quiet period.
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk_i);
    repeat (GUARD) @(posedge clk_i);
  endtask

  // Write one register while the block is idle and mirror it in the predictor.
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    settle_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_THRESHOLD: cfg_thr   = val;
      CFG_COUNT:     cfg_count = val;
      CFG_OWN_SLOT:  cfg_own   = val;
      default: ;  // out-of-map index is ignored
    endcase
  endtask

  // Present one beat, wait for it to be taken, then queue the tally it must produce.
  task automatic send_item(input logic [2:0] act, input logic [SLOT_W-1:0] slot,
                           input logic [FP_W-1:0] fp, input bit typed, input tally_t want);
    tally_t predicted;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    slot_i        <= slot;
    fingerprint_i <= fp;
    do @(posedge clk_i); while (in_stall_o);
    predicted = tally_step(act, slot, fp);
    pending_tallies.push_back(typed ? want : predicted);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result side: check each accepted beat against the oldest expectation, then
  // pick the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_tallies.size() == 0) begin
        $display("%0t: result with nothing expected: found_slot %0d known %0d count %0d",
                 $time, found_slot_o, known_o, signed_count_o);
        mismatches++;
      end else begin
        head = pending_tallies.pop_front();
        check_field("found_slot", head.found, found_slot_o);
        check_field("known", head.known, known_o);
        check_field("signed_count", head.marked, signed_count_o);
        check_field("quorum_met", head.quorum, quorum_met_o);
        check_field("config_valid", head.valid, config_valid_o);
      end
    end
    out_stall_i <= (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct);
  end

  initial begin
    logic [CFG_W-1:0]  thr_v;
    logic [CFG_W-1:0]  cnt_v;
    logic [CFG_W-1:0]  own_v;
    logic [FP_W-1:0]   fp_v;
    logic [2:0]        act_v;
    int unsigned       roll;
    int unsigned       in_use;
    int unsigned       sent;
    bit                clash;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_THRESHOLD;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    action_i      = ACT_LOAD;
    slot_i        = '0;
    fingerprint_i = '0;
    out_stall_i   = 1'b0;

    // Predictor starts from the reset state
    for (int i = 0; i < SLOTS; i++) fp_table[i] = '0;
    marks     = '0;
    cfg_thr   = 8'd1;
    cfg_count = 8'd1;
    cfg_own   = NO_SLOT;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed script. Typed tallies are packed as found, known, count, quorum, valid.
    script = '{
      // fresh table is all zero, so a zero fingerprint hits slot 0
      checked_row(ACT_LOOKUP, 4'd0, 32'h0000_0000, '{4'd0, 1'b1, 5'd0, 1'b0, 1'b0}),
      // reset configuration is a valid 1-of-1 with no own slot
      checked_row(ACT_VALIDATE, 4'd0, 32'h0000_0000, '{4'd0, 1'b0, 5'd0, 1'b0, 1'b1}),
      // unused action codes only report
      checked_row(ACT_SPARE_LO, 4'd15, 32'hFFFF_FFFF, '{4'd0, 1'b0, 5'd0, 1'b0, 1'b0}),
      checked_row(ACT_SPARE_HI, 4'd0, 32'h0000_0000, '{4'd0, 1'b0, 5'd0, 1'b0, 1'b0}),
      checked_row(ACT_RECORD, 4'd0, 32'h0000_0000, '{4'd0, 1'b1, 5'd1, 1'b1, 1'b0}),
      checked_row(ACT_CLEAR, 4'd0, 32'h0000_0000, '{4'd0, 1'b0, 5'd0, 1'b0, 1'b0}),
      reg_row(CFG_COUNT, 8'd16),
      checked_row(ACT_LOAD, 4'd0, 32'hFFFF_FFFF, '{4'd0, 1'b0, 5'd0, 1'b0, 1'b0}),
      op_row(ACT_LOAD, 4'd15, 32'h8000_0001),
      op_row(ACT_LOAD, 4'd7, 32'h5A5A_A5A5),
      op_row(ACT_LOOKUP, 4'd0, 32'hFFFF_FFFF),
      op_row(ACT_LOOKUP, 4'd0, 32'h0000_0000),
      op_row(ACT_LOOKUP, 4'd0, 32'h8000_0001),
      op_row(ACT_VALIDATE, 4'd0, 32'h0000_0000),  // zero slots repeat
      op_row(ACT_RECORD, 4'd0, 32'h8000_0001),
      op_row(ACT_RECORD, 4'd0, 32'hDEAD_BEEF),    // unknown: no mark
      reg_row(CFG_THRESHOLD, 8'd0),
      // zero threshold: quorum always met
      checked_row(ACT_CLEAR, 4'd0, 32'h0000_0000, '{4'd0, 1'b0, 5'd0, 1'b1, 1'b0}),
      reg_row(CFG_THRESHOLD, 8'd255),
      reg_row(CFG_COUNT, 8'd255),                 // beyond the table: search 16 slots
      reg_row(CFG_OWN_SLOT, 8'd0),
      reg_row(CFG_SPARE, 8'hAA),
      op_row(ACT_RECORD, 4'd0, 32'hFFFF_FFFF),
      op_row(ACT_VALIDATE, 4'd0, 32'h0000_0000),
      op_row(ACT_LOOKUP, 4'd0, 32'h5A5A_A5A5),
      reg_row(CFG_COUNT, 8'd0),
      // no slots in use: nothing is known and nothing counts
      checked_row(ACT_LOOKUP, 4'd0, 32'hFFFF_FFFF, '{4'd0, 1'b0, 5'd0, 1'b0, 1'b0}),
      checked_row(ACT_VALIDATE, 4'd0, 32'h0000_0000, '{4'd0, 1'b0, 5'd0, 1'b0, 1'b0})
    };
    foreach (script[k]) begin
      if (script[k].is_reg) begin
        write_reg(script[k].idx, script[k].val);
      end else begin
        send_item(script[k].act, script[k].slot, script[k].fp, script[k].typed,
                  script[k].want);
      end
    end

    // Random phases: each sets a configuration, loads distinct fingerprints into
    // the slots in use, validates, then runs a mix weighted toward signatures.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin thr_v = 8'd16;  cnt_v = 8'd16;  own_v = NO_SLOT; end
        1: begin thr_v = 8'd0;   cnt_v = 8'd255; own_v = 8'd0;    end
        2: begin thr_v = 8'd255; cnt_v = 8'd16;  own_v = 8'd15;   end
        3: begin thr_v = 8'd1;   cnt_v = 8'd1;   own_v = 8'd0;    end
        4: begin thr_v = 8'd0;   cnt_v = 8'd0;   own_v = NO_SLOT; end
        default: begin
          // keep counts mostly small: validate time grows with the square
          roll = $urandom_range(99);
          if (roll < 70)      cnt_v = 8'($urandom_range(8, 1));
          else if (roll < 85) cnt_v = 8'd16;
          else if (roll < 95) cnt_v = 8'($urandom_range(15, 9));
          else                cnt_v = 8'($urandom_range(255, 17));
          if ($urandom_range(9) != 0) thr_v = 8'($urandom_range(cnt_v + 1, 0));
          else                        thr_v = 8'($urandom_range(255, 0));
          roll = $urandom_range(9);
          if (roll < 4)      own_v = NO_SLOT;
          else if (roll < 8) own_v = 8'($urandom_range(cnt_v - 1, 0));
          else               own_v = 8'($urandom_range(255, 0));
        end
      endcase
      write_reg(CFG_THRESHOLD, thr_v);
      write_reg(CFG_COUNT, cnt_v);
      write_reg(CFG_OWN_SLOT, own_v);
      if ($urandom_range(3) == 0) write_reg(CFG_SPARE, 8'($urandom_range(255)));

      // Idle pattern: none, sender gaps, receiver stalls, both lightly
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 53; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 53; end
        default: begin tx_idle_pct = 9; rx_stall_pct = 9; end
      endcase

      in_use = (cnt_v < SLOTS) ? cnt_v : SLOTS;
      sent = 0;
      for (int s = 0; s < in_use; s++) begin
        do begin
          fp_v = $urandom;
          clash = 1'b0;
          for (int j = 0; j < s; j++) if (fp_table[j] == fp_v) clash = 1'b1;
        end while (clash);
        send_item(ACT_LOAD, SLOT_W'(s), fp_v, 1'b0, '0);
        sent++;
      end
      send_item(ACT_VALIDATE, SLOT_W'($urandom_range(15)), $urandom, 1'b0, '0);
      sent++;

      while (sent < PHASE_ITEMS) begin
        roll = $urandom_range(99);
        if (roll < 12) begin
          // half the loads draw from pick_fp, which mostly copies an existing fingerprint, to make duplicates
          fp_v = ($urandom_range(1) != 0) ? pick_fp() : $urandom;
          send_item(ACT_LOAD, SLOT_W'($urandom_range(15)), fp_v, 1'b0, '0);
        end else begin
          if (roll < 35)      act_v = ACT_LOOKUP;
          else if (roll < 70) act_v = ACT_RECORD;
          else if (roll < 76) act_v = ACT_CLEAR;
          else if (roll < 90) act_v = ACT_VALIDATE;
          else                act_v = 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
          send_item(act_v, SLOT_W'($urandom_range(15)), pick_fp(), 1'b0, '0);
        end
        sent++;
      end
    end

    // Drain: wait for every tally, then watch for stray beats a while longer
    tx_idle_pct = 0;
    settle_idle();
    repeat (DRAIN) @(posedge clk_i);
    if (mismatches == 0 && pending_tallies.size() == 0) begin
      $display("cosigner_quorum_tracker test passed");
    end else begin
      $display("cosigner_quorum_tracker test failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #50_000_000;
    $display("cosigner_quorum_tracker test failed");
    $finish;
  end

endmodule

@@ cosigner_quorum_tracker.f @@
src/cqt_pkg.sv
src/cqt_fp_store.sv
src/cosigner_quorum_tracker.sv
sim/cosigner_quorum_tracker_test.sv
